### rtl/sipq_pkg.sv
// Shared types and constants for the sorted-insertion priority queue.
package sipq_pkg;

  localparam int CAPACITY = 16;
  localparam int IdxW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CntW     = $clog2(CAPACITY + 1);

  localparam int TagW  = 16;
  localparam int PrioW = 4;
  localparam int StW   = 2;
  localparam int EcntW = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [StW-1:0] ST_OK    = 2'd0;
  localparam logic [StW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic             op;
    logic [TagW-1:0]  item_tag;
    logic [PrioW-1:0] item_priority;
  } in_t;

  typedef struct packed {
    logic [TagW-1:0]  out_tag;
    logic [PrioW-1:0] out_priority;
    logic [StW-1:0]   status;
    logic [EcntW-1:0] entry_count;
  } out_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENQ_RD,
    S_ENQ_CMP,
    S_DEQ_CAP,
    S_DEQ_RD,
    S_DEQ_WR,
    S_DONE
  } state_t;

endpackage

### rtl/sorted_insert_priority_queue.sv
// Top level of the sorted-insertion priority queue with its slot memory and sequencer.
//
// A bounded priority queue of sipq_pkg::CAPACITY entries, each a 16-bit tag
// with a 4-bit priority, kept sorted by descending priority in a single-port
// memory (one access per cycle, either a write or a registered read). An
// enqueue inserts the new entry ahead of every stored entry of equal or lower
// priority, so equal priorities leave last-in-first-out; a dequeue returns
// the head entry.
// Every input beat yields exactly one result beat carrying a status (ok,
// dequeue while empty, enqueue rejected because full) and the entry count
// after the operation; tag and priority are zero except on a good dequeue.
// The block takes one beat at a time and holds in_stall high until that
// beat's result has been loaded into the output register. Cost is set by the
// memory port: each entry moved takes a read, then a write. An enqueue moves
// each entry of equal or lower priority down a slot, then writes the new one;
// a dequeue reads the head, then moves the rest up a slot; a rejected enqueue
// or an empty dequeue goes straight to the finish. The output register lets a
// finished result wait on out_stall while the next beat is already accepted.
module sorted_insert_priority_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sipq_pkg::in_t     in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sipq_pkg::out_t    out_data
);

  // Slot memory: slot 0 is the head of the queue.
  sipq_pkg::entry_t mem [sipq_pkg::CAPACITY];
  sipq_pkg::entry_t rd_data_r;

  logic                        mem_we;
  logic [sipq_pkg::IdxW-1:0]   mem_waddr;
  sipq_pkg::entry_t            mem_wdata;
  logic                        mem_re;
  logic [sipq_pkg::IdxW-1:0]   mem_raddr;

  sipq_pkg::state_t            state_r, state_nxt;
  logic [sipq_pkg::IdxW-1:0]   idx_r, idx_nxt;
  logic [sipq_pkg::CntW-1:0]   count_r, count_nxt;
  sipq_pkg::entry_t            new_r, new_nxt;
  sipq_pkg::entry_t            res_r, res_nxt;
  logic [sipq_pkg::StW-1:0]    res_st_r, res_st_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sipq_pkg::out_t              out_data_r, out_data_nxt;

  logic                        in_acc;
  logic [sipq_pkg::CntW-1:0]   idx_ext;

  assign in_stall  = (state_r != sipq_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idx_ext   = sipq_pkg::CntW'(idx_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sipq_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working registers and the held result carry no reset.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    new_r      <= new_nxt;
    res_r      <= res_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    new_nxt       = new_r;
    res_nxt       = res_r;
    res_st_nxt    = res_st_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = new_r;
    mem_re        = 1'b0;
    mem_raddr     = idx_r;

    unique case (state_r)
      sipq_pkg::S_IDLE: begin
        if (in_acc) begin
          new_nxt.tag  = in_data.item_tag;
          new_nxt.prio = in_data.item_priority;
          res_nxt      = '0;
          res_st_nxt   = sipq_pkg::ST_OK;
          if (in_data.op == sipq_pkg::OP_ENQ) begin
            if (count_r == sipq_pkg::CntW'(sipq_pkg::CAPACITY)) begin
              res_st_nxt = sipq_pkg::ST_FULL;
              state_nxt  = sipq_pkg::S_DONE;
            end else begin
              idx_nxt   = count_r[sipq_pkg::IdxW-1:0];
              state_nxt = sipq_pkg::S_ENQ_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_st_nxt = sipq_pkg::ST_EMPTY;
              state_nxt  = sipq_pkg::S_DONE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              state_nxt = sipq_pkg::S_DEQ_CAP;
            end
          end
        end
      end
      sipq_pkg::S_ENQ_RD: begin
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          count_nxt = count_r + 1'b1;
          state_nxt = sipq_pkg::S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r - 1'b1;
          state_nxt = sipq_pkg::S_ENQ_CMP;
        end
      end
      sipq_pkg::S_ENQ_CMP: begin
        mem_we = 1'b1;
        if (rd_data_r.prio > new_r.prio) begin
          count_nxt = count_r + 1'b1;
          state_nxt = sipq_pkg::S_DONE;
        end else begin
          mem_wdata = rd_data_r;
          idx_nxt   = idx_r - 1'b1;
          state_nxt = sipq_pkg::S_ENQ_RD;
        end
      end
      sipq_pkg::S_DEQ_CAP: begin
        res_nxt   = rd_data_r;
        idx_nxt   = '0;
        state_nxt = sipq_pkg::S_DEQ_RD;
      end
      sipq_pkg::S_DEQ_RD: begin
        if ((idx_ext + 1'b1) >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = sipq_pkg::S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + 1'b1;
          state_nxt = sipq_pkg::S_DEQ_WR;
        end
      end
      sipq_pkg::S_DEQ_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data_r;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = sipq_pkg::S_DEQ_RD;
      end
      sipq_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt.out_tag      = res_r.tag;
          out_data_nxt.out_priority = res_r.prio;
          out_data_nxt.status       = res_st_r;
          out_data_nxt.entry_count  = sipq_pkg::EcntW'(count_r);
          out_valid_nxt             = 1'b1;
          state_nxt                 = sipq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sipq_pkg::S_IDLE;
      end
    endcase
  end

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sipq_pkg::CntW'(sipq_pkg::CAPACITY))
    else $error("entry count exceeds capacity");

  // Writes never land beyond the slot just past the last stored entry.
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (sipq_pkg::CntW'(mem_waddr) <= count_r))
    else $error("slot write outside the stored range");

  // A rejected enqueue leaves the count untouched.
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == sipq_pkg::OP_ENQ
     && count_r == sipq_pkg::CntW'(sipq_pkg::CAPACITY))
    |=> (count_r == sipq_pkg::CntW'(sipq_pkg::CAPACITY)))
    else $error("count changed on a rejected enqueue");

  // A new result is loaded only at the end of an operation.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == sipq_pkg::S_DONE))
    else $error("result appeared outside the finish step");

  // A dequeue from a non-empty queue always starts with a read of the head slot.
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == sipq_pkg::OP_DEQ && count_r != '0)
    |=> (state_r == sipq_pkg::S_DEQ_CAP))
    else $error("dequeue did not start its head read");

endmodule

### tb/tb.sv
// Self-checking testbench for the sorted-insertion priority queue.
`timescale 1ns / 1ps

module tb;

  // Each beat waits at most this long on the sender side and on the receiver side.
  localparam int MaxIdle = 11;
  // This limit leaves several times the margin that roughly 1500 beats need in
  // the worst case of sender idle, block work and receiver stall.
  localparam int CycleLimit = 400000;
  // After the last expected response, wait this long for stray responses. The
  // longest operation is a dequeue from a full queue.
  localparam int DrainCycles = 64;

  // Shadow copy of the queue contents, plus the responses still owed by the block.
  class priority_queue_tracker;
    logic [sipq_pkg::TagW-1:0]  shadow_tag  [sipq_pkg::CAPACITY];
    logic [sipq_pkg::PrioW-1:0] shadow_prio [sipq_pkg::CAPACITY];
    int                         shadow_count;
    sipq_pkg::out_t             awaited_responses[$];
    int                         errors;

    function new();
      shadow_count = 0;
      errors       = 0;
    endfunction

    task report_mismatch(string what);
      $display("[%0t] MISMATCH: %0s", $realtime, what);
      errors++;
    endtask

    // Apply one operation to the shadow queue and return the response it produces.
    function sipq_pkg::out_t predict_response(sipq_pkg::in_t beat);
      sipq_pkg::out_t resp;
      int             pos;
      resp = '0;
      if (beat.op == sipq_pkg::OP_ENQ) begin
        if (shadow_count >= sipq_pkg::CAPACITY) begin
          resp.status = sipq_pkg::ST_FULL;
        end else begin
          // The new entry goes ahead of every entry of equal or lower priority,
          // so among equal priorities the newest one comes out first.
          pos = 0;
          while (pos < shadow_count && shadow_prio[pos] > beat.item_priority) pos++;
          for (int i = shadow_count; i > pos; i--) begin
            shadow_tag[i]  = shadow_tag[i-1];
            shadow_prio[i] = shadow_prio[i-1];
          end
          shadow_tag[pos]  = beat.item_tag;
          shadow_prio[pos] = beat.item_priority;
          shadow_count++;
          resp.status = sipq_pkg::ST_OK;
        end
      end else if (shadow_count == 0) begin
        resp.status = sipq_pkg::ST_EMPTY;
      end else begin
        resp.out_tag      = shadow_tag[0];
        resp.out_priority = shadow_prio[0];
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_tag[i]  = shadow_tag[i+1];
          shadow_prio[i] = shadow_prio[i+1];
        end
        shadow_count--;
        resp.status = sipq_pkg::ST_OK;
      end
      // Only the low bits of the count are reported.
      resp.entry_count = sipq_pkg::EcntW'(shadow_count);
      return resp;
    endfunction

    function void note_request(sipq_pkg::in_t beat);
      awaited_responses.push_back(predict_response(beat));
    endfunction

    task check_response(sipq_pkg::out_t got);
      sipq_pkg::out_t want;
      if (awaited_responses.size() == 0) begin
        report_mismatch($sformatf("response %h arrived with none expected", got));
      end else begin
        want = awaited_responses.pop_front();
        if (got.out_tag !== want.out_tag)
          report_mismatch($sformatf("out_tag %h, expected %h", got.out_tag, want.out_tag));
        if (got.out_priority !== want.out_priority)
          report_mismatch($sformatf("out_priority %h, expected %h",
                                    got.out_priority, want.out_priority));
        if (got.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    got.entry_count, want.entry_count));
      end
    endtask

    task check_leftovers();
      while (awaited_responses.size() != 0) begin
        report_mismatch($sformatf("expected response %h never arrived",
                                  awaited_responses.pop_front()));
      end
    endtask
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_stall;
  sipq_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_stall;
  sipq_pkg::out_t out_data;

  priority_queue_tracker tracker;

  // When set, neither side idles, so back-to-back beats and results get exercised.
  bit no_idle;
  // Remaining cycles the receiver holds out_stall high before taking the next beat.
  int hold_cycles;
  int cycle_count;

  sorted_insert_priority_queue u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog. It fires only if the block stops making progress.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // All handshake sampling happens at the rising edge. Stimulus changes only at
  // the falling edge, so the values seen here are stable. A result cannot leave
  // in the same cycle as the beat that caused it, so the order of the two checks
  // does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) tracker.note_request(in_data);
      if (out_valid && !out_stall) begin
        tracker.check_response(out_data);
        hold_cycles = no_idle ? 0 : $urandom_range(0, MaxIdle);
      end
    end
  end

  // Receiver side. After each accepted result, stall for the number of cycles
  // drawn for it. The stall can fall on any phase of the block's sequencing.
  always @(negedge clk) begin
    out_stall <= (hold_cycles > 0);
    if (hold_cycles > 0) hold_cycles--;
  end

  // Send one beat. The task is entered and left at a falling edge. When no gap
  // is drawn, valid stays high straight into the next beat.
  task automatic send_beat(logic op, logic [sipq_pkg::TagW-1:0] tag,
                           logic [sipq_pkg::PrioW-1:0] prio);
    int            gap;
    sipq_pkg::in_t beat;
    gap = no_idle ? 0 : $urandom_range(0, MaxIdle);
    beat.op            = op;
    beat.item_tag      = tag;
    beat.item_priority = prio;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    int enq_pct;
    int prio_top;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    rst_n       = 1'b0;
    no_idle     = 1'b0;
    hold_cycles = 0;
    tracker     = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Start with a dequeue on the empty queue.
    send_beat(sipq_pkg::OP_DEQ, 16'h0000, 4'h0);
    // Tag and priority extremes.
    send_beat(sipq_pkg::OP_ENQ, 16'h0000, 4'h0);
    send_beat(sipq_pkg::OP_ENQ, 16'hFFFF, 4'hF);
    // Equal priorities in the middle, at the head and at the tail. These must
    // leave newest first.
    send_beat(sipq_pkg::OP_ENQ, 16'h1234, 4'h7);
    send_beat(sipq_pkg::OP_ENQ, 16'h1235, 4'h7);
    send_beat(sipq_pkg::OP_ENQ, 16'h1236, 4'h7);
    send_beat(sipq_pkg::OP_ENQ, 16'hAAAA, 4'hF);
    send_beat(sipq_pkg::OP_ENQ, 16'h5555, 4'h0);
    // Fill the queue to capacity with mixed priorities.
    for (int k = 0; k < sipq_pkg::CAPACITY - 7; k++) begin
      send_beat(sipq_pkg::OP_ENQ, sipq_pkg::TagW'(16'h0100 + k),
                sipq_pkg::PrioW'((k * 5) % 16));
    end
    // An enqueue on the full queue is rejected, even at top priority.
    send_beat(sipq_pkg::OP_ENQ, 16'hFFFF, 4'hF);
    // Dequeues with all ignored field bits set, then one refill at the head.
    for (int k = 0; k < 6; k++) begin
      send_beat(sipq_pkg::OP_DEQ, 16'hFFFF, 4'hF);
    end
    send_beat(sipq_pkg::OP_ENQ, 16'hC3A5, 4'hF);

    // Random part. Each phase biases toward filling or draining, so both full
    // and empty are reached often. Narrow priority ranges give many ties.
    for (int n = 0; n < 1450; n++) begin
      if (n % 48 == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            enq_pct = 15;
          end
          1: begin
            enq_pct = 50;
          end
          default: begin
            enq_pct = 85;
          end
        endcase
        prio_top = ($urandom_range(0, 1) == 0) ? 2 : 15;
        no_idle  = ($urandom_range(0, 3) == 0);
      end
      send_beat(($urandom_range(0, 99) < enq_pct) ? sipq_pkg::OP_ENQ : sipq_pkg::OP_DEQ,
                sipq_pkg::TagW'($urandom), sipq_pkg::PrioW'($urandom_range(0, prio_top)));
    end
    in_valid <= 1'b0;

    while (tracker.awaited_responses.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    tracker.check_leftovers();
    if (tracker.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sorted_insert_priority_queue.f
rtl/sipq_pkg.sv
rtl/sorted_insert_priority_queue.sv
tb/tb.sv
